// File: rtl/core/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; the front end, normalize engine, back end and top import it.
package qau_pkg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_CONJ = 2'd1,
        OP_NORM = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // status of the normalize engine as seen by the back end
    typedef struct packed {
        logic busy;
        logic done;
    } norm_stat_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

endpackage

// File: rtl/core/qau_if.sv
// Valid/ready channel interfaces for the quaternion arithmetic unit.
// Depends on nothing; width set by the W parameter.
interface qau_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;

    modport source (output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink   (input valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    output ready);
endinterface

interface qau_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r_w;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic                saturated;
    logic                zero_magnitude;

    modport source (output valid, r_w, r_x, r_y, r_z, saturated, zero_magnitude,
                    input ready);
    modport sink   (input valid, r_w, r_x, r_y, r_z, saturated, zero_magnitude,
                     output ready);
endinterface

// File: rtl/core/qau_front.sv
// Front end: accepts input beats, classifies the command and queues them.
// Depends on qau_pkg and qau_in_if.
module qau_front #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    qau_in_if.sink               in_ch,
    output logic                 head_valid,
    output qau_pkg::op_t         head_op,
    output logic signed [W-1:0]  head_a [4],
    output logic signed [W-1:0]  head_b [4],
    input  logic                 pop
);
    import qau_pkg::*;

    op_t                 op_mem [QUEUE_DEPTH];
    logic signed [W-1:0] a_mem  [QUEUE_DEPTH][4];
    logic signed [W-1:0] b_mem  [QUEUE_DEPTH][4];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;

    assign in_ch.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign head_valid  = (count_reg != '0);
    assign head_op     = op_mem[rd_ptr_reg];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            head_a[i] = a_mem[rd_ptr_reg][i];
            head_b[i] = b_mem[rd_ptr_reg][i];
        end
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]    <= op_t'(in_ch.cmd);
            a_mem[wr_ptr_reg][0]  <= in_ch.a_w;
            a_mem[wr_ptr_reg][1]  <= in_ch.a_x;
            a_mem[wr_ptr_reg][2]  <= in_ch.a_y;
            a_mem[wr_ptr_reg][3]  <= in_ch.a_z;
            b_mem[wr_ptr_reg][0]  <= in_ch.b_w;
            b_mem[wr_ptr_reg][1]  <= in_ch.b_x;
            b_mem[wr_ptr_reg][2]  <= in_ch.b_y;
            b_mem[wr_ptr_reg][3]  <= in_ch.b_z;
        end
    end

endmodule

// File: rtl/core/qau_norm.sv
// Normalize engine: sum of squares, bit-serial square root, four
// bit-serial dividers in parallel. Depends on qau_pkg.
module qau_norm #(
    parameter int W = 32,
    parameter int F = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] a_in [4],
    input  logic                ack,
    output qau_pkg::norm_stat_t stat,
    output logic [W-1:0]        r [4],
    output logic                sat,
    output logic                zm
);
    import qau_pkg::*;

    localparam int N   = W + 1;          // root bits
    localparam int SW  = 2 * N;          // radicand bits
    localparam int RW  = N + 2;          // root remainder bits
    localparam int NW  = W + F + 1;      // dividend / quotient bits
    localparam int DRW = W + 2;          // divider remainder bits
    localparam int CW  = $clog2(NW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_SUM, S_ROOT, S_CHK, S_DIV, S_FIN, S_DONE
    } state_t;

    state_t            state_reg;
    logic [W-1:0]      mag_reg [4];
    logic              neg_reg [4];
    logic [2*W-1:0]    sq_reg  [4];
    logic [SW-1:0]     rad_reg;
    logic [RW-1:0]     rem_reg;
    logic [N-1:0]      root_reg;
    logic [CW-1:0]     cnt_reg;
    logic [N-1:0]      m_reg;
    logic [NW-1:0]     num_reg [4];
    logic [DRW-1:0]    drem_reg [4];
    logic [W-1:0]      r_reg [4];
    logic              sat_reg;
    logic              zm_reg;

    logic [RW-1:0]     rem_sh, trial;
    logic              root_bit;
    logic [DRW-1:0]    drem_sh [4];
    logic              q_bit   [4];
    logic [W-1:0]      fin_r   [4];
    logic              fin_sat [4];

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    always_comb
    begin
        rem_sh   = {rem_reg[RW-3:0], rad_reg[SW-1:SW-2]};
        trial    = {root_reg, 2'b01};
        root_bit = (rem_sh >= trial);
        for (int i = 0; i < 4; i++)
        begin
            drem_sh[i] = {drem_reg[i][DRW-2:0], num_reg[i][NW-1]};
            q_bit[i]   = (drem_sh[i] >= DRW'(m_reg));
            // clip quotient and apply the sign of the source component
            if (neg_reg[i])
            begin
                fin_sat[i] = (num_reg[i] > NW'(MINV));
                fin_r[i]   = fin_sat[i] ? MINV : W'(-num_reg[i]);
            end
            else
            begin
                fin_sat[i] = (num_reg[i] > NW'(MAXV));
                fin_r[i]   = fin_sat[i] ? MAXV : num_reg[i][W-1:0];
            end
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign r         = r_reg;
    assign sat       = sat_reg;
    assign zm        = zm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    cnt_reg   <= CW'(N);
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    cnt_reg   <= CW'(NW);
                    state_reg <= (root_reg == '0) ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    neg_reg[i] <= a_in[i][W-1];
                    mag_reg[i] <= a_in[i][W-1] ? W'(-a_in[i]) : W'(a_in[i]);
                end
            end
            S_SQ:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    sq_reg[i] <= mag_reg[i] * mag_reg[i];
                end
            end
            S_SUM:
            begin
                rad_reg  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2])
                            + SW'(sq_reg[3]);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_ROOT:
            begin
                rad_reg  <= {rad_reg[SW-3:0], 2'b00};
                rem_reg  <= root_bit ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[N-2:0], root_bit};
            end
            S_CHK:
            begin
                m_reg   <= root_reg;
                zm_reg  <= (root_reg == '0);
                sat_reg <= 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    // dividend = |a| * 2^F + floor(M / 2), rounds half away from zero
                    num_reg[i]  <= {1'b0, mag_reg[i], {F{1'b0}}} + NW'(root_reg >> 1);
                    drem_reg[i] <= '0;
                    r_reg[i]    <= '0;
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    drem_reg[i] <= q_bit[i] ? drem_sh[i] - DRW'(m_reg) : drem_sh[i];
                    num_reg[i]  <= {num_reg[i][NW-2:0], q_bit[i]};
                end
            end
            S_FIN:
            begin
                sat_reg <= fin_sat[0] | fin_sat[1] | fin_sat[2] | fin_sat[3];
                for (int i = 0; i < 4; i++)
                begin
                    r_reg[i] <= fin_r[i];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/qau_back.sv
// Back end: issue from the queue, product stage, sum/round/saturate stage
// that doubles as the output register. Depends on qau_pkg, qau_out_if, qau_norm.
module qau_back #(
    parameter int W = 32,
    parameter int F = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  qau_pkg::op_t        head_op,
    input  logic signed [W-1:0] head_a [4],
    input  logic signed [W-1:0] head_b [4],
    output logic                pop,
    qau_out_if.source           out_ch
);
    import qau_pkg::*;

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    norm_stat_t        nstat;
    logic [W-1:0]      n_r [4];
    logic              n_sat, n_zm;
    logic              n_start, n_ack;

    qau_norm #(.W(W), .F(F)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .a_in  (head_a),
        .ack   (n_ack),
        .stat  (nstat),
        .r     (n_r),
        .sat   (n_sat),
        .zm    (n_zm)
    );

    // product stage
    logic                 a_valid_reg;
    logic                 a_mul_reg;
    logic signed [PW-1:0] prod_reg [16];
    logic [W-1:0]         a_res_reg [4];
    logic                 a_sat_reg, a_zm_reg;

    // output stage
    logic                 o_valid_reg;
    logic [W-1:0]         o_r_reg [4];
    logic                 o_sat_reg, o_zm_reg;

    logic                 b_adv, a_free, eng_take, head_go, load_head;
    logic [W-1:0]         dir_r [4];
    logic                 dir_sat;
    logic signed [SW-1:0] t [4];
    logic [W-1:0]         m_r [4];
    logic                 m_sat [4];

    function automatic logic signed [SW-1:0] px(input logic signed [PW-1:0] p);
        px = SW'(p);
    endfunction

    assign b_adv     = !o_valid_reg || out_ch.ready;
    assign a_free    = !a_valid_reg || b_adv;
    assign eng_take  = nstat.done && a_free;
    assign n_ack     = eng_take;
    assign head_go   = head_valid && !nstat.busy;
    assign n_start   = head_go && (head_op == OP_NORM);
    assign load_head = head_go && (head_op != OP_NORM) && a_free;
    assign pop       = n_start || load_head;

    // results that need no products: conjugate and the unused code
    always_comb
    begin
        dir_sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dir_r[i] = '0;
        end
        if (head_op == OP_CONJ)
        begin
            dir_r[0] = head_a[0];
            for (int i = 1; i < 4; i++)
            begin
                if (head_a[i] == MINV)
                begin
                    dir_r[i] = MAXV;
                    dir_sat  = 1'b1;
                end
                else
                begin
                    dir_r[i] = W'(-head_a[i]);
                end
            end
        end
    end

    // Hamilton product sums, then round half up and clip
    always_comb
    begin
        logic signed [SW-1:0] rnd;
        logic signed [SW-1:0] shv;
        t[0] = px(prod_reg[0])  - px(prod_reg[5])  - px(prod_reg[10]) - px(prod_reg[15]);
        t[1] = px(prod_reg[1])  + px(prod_reg[4])  + px(prod_reg[11]) - px(prod_reg[14]);
        t[2] = px(prod_reg[2])  + px(prod_reg[8])  + px(prod_reg[13]) - px(prod_reg[7]);
        t[3] = px(prod_reg[3])  + px(prod_reg[12]) + px(prod_reg[6])  - px(prod_reg[9]);
        for (int i = 0; i < 4; i++)
        begin
            rnd = t[i] + (SW'(1) <<< (F - 1));
            shv = rnd >>> F;
            if (shv > SW'(MAXV))
            begin
                m_r[i]   = MAXV;
                m_sat[i] = 1'b1;
            end
            else if (shv < SW'(MINV))
            begin
                m_r[i]   = MINV;
                m_sat[i] = 1'b1;
            end
            else
            begin
                m_r[i]   = shv[W-1:0];
                m_sat[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= eng_take || load_head;
            end
            if (b_adv)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            if (eng_take)
            begin
                a_mul_reg <= 1'b0;
                a_res_reg <= n_r;
                a_sat_reg <= n_sat;
                a_zm_reg  <= n_zm;
            end
            else
            begin
                a_mul_reg <= (head_op == OP_MUL);
                a_res_reg <= dir_r;
                a_sat_reg <= dir_sat;
                a_zm_reg  <= 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        prod_reg[i*4+j] <= head_a[i] * head_b[j];
                    end
                end
            end
        end
        if (b_adv)
        begin
            if (a_mul_reg)
            begin
                o_r_reg   <= m_r;
                o_sat_reg <= m_sat[0] | m_sat[1] | m_sat[2] | m_sat[3];
                o_zm_reg  <= 1'b0;
            end
            else
            begin
                o_r_reg   <= a_res_reg;
                o_sat_reg <= a_sat_reg;
                o_zm_reg  <= a_zm_reg;
            end
        end
    end

    assign out_ch.valid          = o_valid_reg;
    assign out_ch.r_w            = o_r_reg[0];
    assign out_ch.r_x            = o_r_reg[1];
    assign out_ch.r_y            = o_r_reg[2];
    assign out_ch.r_z            = o_r_reg[3];
    assign out_ch.saturated      = o_sat_reg;
    assign out_ch.zero_magnitude = o_zm_reg;

endmodule

// File: rtl/core/quaternion_arith_unit_core.sv
// Top level of the quaternion arithmetic unit: front queue plus back end.
// Depends on qau_pkg, qau_if, qau_front, qau_back.
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   cmd, a_w..a_z, b_w..b_z
//   out_ch    out   valid/ready   r_w..r_z, saturated, zero_magnitude
//
// Multiply, conjugate and unused codes: one beat per cycle while the output is not
// stalled and the normalize engine is idle; a result passes the queue, the product
// stage and the output register. Normalize: sum of squares, bit-serial square
// root and dividers in turn (a zero magnitude skips the dividers); later beats
// wait in the 4-entry queue.
// rst_n clears the queue, pipeline valids and engine state asynchronously.
// A stalled output holds its beat; the queue keeps taking input until full.
module quaternion_arith_unit_core #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 29
) (
    input  logic      clk,
    input  logic      rst_n,
    qau_in_if.sink    in_ch,
    qau_out_if.source out_ch
);
    import qau_pkg::*;

    logic                         head_valid;
    op_t                          head_op;
    logic signed [COMP_WIDTH-1:0] head_a [4];
    logic signed [COMP_WIDTH-1:0] head_b [4];
    logic                         pop;

    qau_front #(.W(COMP_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_a     (head_a),
        .head_b     (head_b),
        .pop        (pop)
    );

    qau_back #(.W(COMP_WIDTH), .F(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_a     (head_a),
        .head_b     (head_b),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// File: rtl/core/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit, bound to the top.
// Depends on quaternion_arith_unit_core and its interfaces.
module qau_props #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] r_w,
    input logic [W-1:0] r_x,
    input logic [W-1:0] r_y,
    input logic [W-1:0] r_z,
    input logic         saturated,
    input logic         zero_magnitude
);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_w) && $stable(r_x)
            && $stable(r_y) && $stable(r_z) && $stable(saturated))
        else $error("output beat changed while stalled");

    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_magnitude |-> r_w == '0 && r_x == '0 && r_y == '0
            && r_z == '0 && !saturated)
        else $error("zero magnitude beat not all zero");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> r_w == MAXV || r_w == MINV || r_x == MAXV
            || r_x == MINV || r_y == MAXV || r_y == MINV || r_z == MAXV
            || r_z == MINV)
        else $error("saturated beat has no clipped component");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("output beat with no input accepted");

endmodule

bind quaternion_arith_unit_core qau_props #(.W(COMP_WIDTH)) u_qau_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .r_w            (out_ch.r_w),
    .r_x            (out_ch.r_x),
    .r_y            (out_ch.r_y),
    .r_z            (out_ch.r_z),
    .saturated      (out_ch.saturated),
    .zero_magnitude (out_ch.zero_magnitude)
);
